// ===== src/dsc_pkg.sv =====
// Shared constants, opcodes and controller/datapath interface types for the DFA string checker.
package dsc_pkg;

    // Table geometry and counter width
    localparam int MAX_STATES = 256;
    localparam int ALPHABET   = 16;
    localparam int COUNT_BITS = 32;
    localparam int PAIRS      = MAX_STATES * ALPHABET;
    localparam int PAIR_W     = $clog2(PAIRS);
    localparam int SIDX_W     = $clog2(MAX_STATES);

    // Fixed field widths
    localparam int OP_W    = 3;
    localparam int ST_W    = 8;
    localparam int SYM_W   = 4;
    localparam int VISIT_W = 33;
    localparam int TALLY_W = 32;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 112;

    // Opcodes
    localparam logic [OP_W-1:0] OP_WR_TRANS = 3'd0;
    localparam logic [OP_W-1:0] OP_WR_ACC   = 3'd1;
    localparam logic [OP_W-1:0] OP_SYMBOL   = 3'd2;
    localparam logic [OP_W-1:0] OP_END      = 3'd3;
    localparam logic [OP_W-1:0] OP_READ     = 3'd4;

    // Result kinds
    localparam logic KIND_VERDICT = 1'b0;
    localparam logic KIND_COUNT   = 1'b1;

    // Run modes
    localparam logic MODE_CHECK    = 1'b0;
    localparam logic MODE_CLASSIFY = 1'b1;

    // Configuration register indexes
    localparam logic CFG_INIT_STATE = 1'b0;
    localparam logic CFG_RUN_MODE   = 1'b1;

    // Controller to datapath
    typedef struct packed {
        logic sweep;    // write zero at the clearing address, advance it
        logic take;     // input transfer this cycle
        logic step;     // apply one symbol
        logic finish;   // close the string and load a verdict
        logic readout;  // load a count readout
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic sweep_last;  // clearing address at the last entry
        logic out_free;    // output register can take a result
        logic item_last;   // held item ends its string
    } t_dp_sts;

endpackage

// ===== src/dfa_string_checker.sv =====
// Top level of the table-driven DFA string checker with per-transition visit counts.
//
// The block runs a deterministic automaton held in on-chip tables. Input transfers carry one
// command each: write a transition, write an accepting flag, feed a string symbol (tlast marks
// the symbol that ends the string), end an empty or open string, or read the visit count of one
// (state, symbol) pair. In check mode each symbol bumps a saturating positive or negative count
// chosen by the label, and the string verdict tells whether acceptance matched the label; a
// sticky all-ok flag drops on any mismatch. In classify mode counts hold, and the verdict is 1
// only when every taken transition had a nonzero positive count and the end state accepts;
// saturating tallies count ones and zeros. After reset the block runs a clearing pass over the
// 4096-entry transition and count memories (and the 256 accepting flags) and holds tready low
// until the pass ends; configuration writes are taken during that time. The transition memory
// read is registered, and its data forms the next address. Table writes and ignored opcodes
// are taken in IDLE alone; a symbol then passes through STEP, a symbol that ends its string
// through STEP and FINISH, an end-of-string through FINISH and a count readout through COUNT;
// FINISH and COUNT wait only while the output register still holds an untaken result.
module dfa_string_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Command stream
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // tdata, from bit 0: opcode[3], state_index[8], symbol[4], next_state[8],
    // accepting[1], label[1], zero fill[7]
    input  logic [dsc_pkg::IN_DATA_W-1:0]  i_s_tdata,
    input  logic                           i_s_tlast,   // last_symbol
    // Result stream
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // tdata, from bit 0: verdict[1], end_state[8], visit_count[33], all_strings_ok[1],
    // ones_total[32], zeros_total[32], zero fill[5]
    output logic [dsc_pkg::OUT_DATA_W-1:0] o_m_tdata,
    output logic                           o_m_tuser,   // kind
    // Configuration writes: index 0 start state of each string, index 1 run_mode
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_idx,
    input  logic [dsc_pkg::ST_W-1:0]       i_cfg_data
);

    dsc_pkg::t_dp_cmd w_cmd;
    dsc_pkg::t_dp_sts w_sts;

    // Unpack the command fields
    logic [dsc_pkg::OP_W-1:0]  w_opcode;
    logic [dsc_pkg::ST_W-1:0]  w_state_index;
    logic [dsc_pkg::SYM_W-1:0] w_symbol;
    logic [dsc_pkg::ST_W-1:0]  w_next_state;
    logic                      w_accepting;
    logic                      w_label;

    assign w_opcode      = i_s_tdata[2:0];
    assign w_state_index = i_s_tdata[10:3];
    assign w_symbol      = i_s_tdata[14:11];
    assign w_next_state  = i_s_tdata[22:15];
    assign w_accepting   = i_s_tdata[23];
    assign w_label       = i_s_tdata[24];

    // Sequence the clearing pass and each transfer
    dsc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_opcode   (w_opcode),
        .i_sts      (w_sts),
        .o_s_tready (o_s_tready),
        .o_cmd      (w_cmd)
    );

    // Tables, string state and result register
    dsc_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_opcode      (w_opcode),
        .i_state_index (w_state_index),
        .i_symbol      (w_symbol),
        .i_next_state  (w_next_state),
        .i_accepting   (w_accepting),
        .i_label       (w_label),
        .i_last_symbol (i_s_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_m_tready    (i_m_tready),
        .o_m_tvalid    (o_m_tvalid),
        .o_m_tdata     (o_m_tdata),
        .o_m_tuser     (o_m_tuser)
    );

endmodule

// ===== src/dsc_ctrl.sv =====
// Controller state machine: clearing pass, item dispatch and result sequencing.
module dsc_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    input  logic [dsc_pkg::OP_W-1:0]  i_opcode,
    input  dsc_pkg::t_dp_sts          i_sts,
    output logic                      o_s_tready,
    output dsc_pkg::t_dp_cmd          o_cmd
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_STEP   = 3'd2;
    localparam logic [2:0] S_FINISH = 3'd3;
    localparam logic [2:0] S_COUNT  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        o_cmd         = '0;
        o_cmd.sweep   = (r_state == S_CLEAR);
        o_cmd.take    = (r_state == S_IDLE) && i_s_tvalid;
        o_cmd.step    = (r_state == S_STEP);
        o_cmd.finish  = (r_state == S_FINISH) && i_sts.out_free;
        o_cmd.readout = (r_state == S_COUNT) && i_sts.out_free;
        o_s_tready    = (r_state == S_IDLE);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_sts.sweep_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_s_tvalid) begin
                    case (i_opcode)
                        dsc_pkg::OP_SYMBOL: n_state = S_STEP;
                        dsc_pkg::OP_END:    n_state = S_FINISH;
                        dsc_pkg::OP_READ:   n_state = S_COUNT;
                        default:            n_state = S_IDLE;
                    endcase
                end
            end
            S_STEP: begin
                n_state = i_sts.item_last ? S_FINISH : S_IDLE;
            end
            S_FINISH: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            S_COUNT: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== src/dsc_datapath.sv =====
// Datapath: transition, flag and count memories, string state, tallies and output register.
module dsc_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  dsc_pkg::t_dp_cmd               i_cmd,
    output dsc_pkg::t_dp_sts               o_sts,
    input  logic [dsc_pkg::OP_W-1:0]       i_opcode,
    input  logic [dsc_pkg::ST_W-1:0]       i_state_index,
    input  logic [dsc_pkg::SYM_W-1:0]      i_symbol,
    input  logic [dsc_pkg::ST_W-1:0]       i_next_state,
    input  logic                           i_accepting,
    input  logic                           i_label,
    input  logic                           i_last_symbol,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_idx,
    input  logic [dsc_pkg::ST_W-1:0]       i_cfg_data,
    input  logic                           i_m_tready,
    output logic                           o_m_tvalid,
    output logic [dsc_pkg::OUT_DATA_W-1:0] o_m_tdata,
    output logic                           o_m_tuser
);

    localparam int PW  = dsc_pkg::PAIR_W;
    localparam int SW  = dsc_pkg::SIDX_W;
    localparam int CB  = dsc_pkg::COUNT_BITS;
    localparam int STW = dsc_pkg::ST_W;
    localparam int TW  = dsc_pkg::TALLY_W;
    localparam int VW  = dsc_pkg::VISIT_W;
    localparam int SUM_W = (CB + 1 > VW) ? CB + 1 : VW;
    localparam logic [VW-1:0] VISIT_MAX = '1;

    function automatic logic pair_ok(input logic [STW-1:0] st,
                                     input logic [dsc_pkg::SYM_W-1:0] sym);
        return (32'(st) < dsc_pkg::MAX_STATES) && (32'(sym) < dsc_pkg::ALPHABET);
    endfunction

    function automatic logic [PW-1:0] pair_at(input logic [STW-1:0] st,
                                              input logic [dsc_pkg::SYM_W-1:0] sym);
        return PW'(st) * PW'(dsc_pkg::ALPHABET) + PW'(sym);
    endfunction

    // Memories
    logic [STW-1:0] mem_trans [dsc_pkg::PAIRS];
    logic [CB-1:0]  mem_pos   [dsc_pkg::PAIRS];
    logic [CB-1:0]  mem_neg   [dsc_pkg::PAIRS];
    logic           mem_acc   [dsc_pkg::MAX_STATES];

    // Control and state registers
    logic [PW-1:0]  r_sweep_cnt;
    logic [STW-1:0] r_start;
    logic           r_mode;
    logic [STW-1:0] r_cur;
    logic           r_in_str;
    logic           r_seen;
    logic           r_ok;
    logic [TW-1:0]  r_ones;
    logic [TW-1:0]  r_zeros;
    logic           r_out_valid;

    // Held item and read data
    logic           r_label;
    logic           r_last;
    logic           r_pair_ok;
    logic [PW-1:0]  r_pair;
    logic [STW-1:0] r_trans_q;
    logic [CB-1:0]  r_pos_q;
    logic [CB-1:0]  r_neg_q;
    logic           r_acc_q;
    logic           r_acc_ok;

    // Output payload
    logic           r_out_kind;
    logic           r_out_verdict;
    logic [STW-1:0] r_out_end;
    logic [VW-1:0]  r_out_visit;
    logic           r_out_ok;
    logic [TW-1:0]  r_out_ones;
    logic [TW-1:0]  r_out_zeros;

    // Address and data selection
    logic [STW-1:0] cur_now;
    logic [STW-1:0] rd_st;
    logic [PW-1:0]  rd_pair;
    logic           rd_pair_ok;
    logic           trans_we;
    logic [PW-1:0]  trans_wa;
    logic [STW-1:0] trans_wd;
    logic           cnt_we;
    logic           cnt_pos_sel;
    logic [PW-1:0]  cnt_wa;
    logic [CB-1:0]  pos_wd;
    logic [CB-1:0]  neg_wd;
    logic           acc_we;
    logic [SW-1:0]  acc_wa;
    logic           acc_wd;
    logic           acc_re;
    logic [STW-1:0] acc_rst;

    // Symbol step
    logic [CB-1:0]  pos_new;
    logic [CB-1:0]  neg_new;
    logic [STW-1:0] n_cur_step;
    logic           seen_step;

    // String end
    logic [STW-1:0] fin_st;
    logic           fin_acc;
    logic           fin_verdict;
    logic           n_ok;
    logic [TW-1:0]  n_ones;
    logic [TW-1:0]  n_zeros;
    logic [SUM_W-1:0] sum;
    logic [VW-1:0]  visit;

    always_comb begin
        cur_now    = r_in_str ? r_cur : r_start;
        rd_st      = (i_opcode == dsc_pkg::OP_READ) ? i_state_index : cur_now;
        rd_pair    = pair_at(rd_st, i_symbol);
        rd_pair_ok = pair_ok(rd_st, i_symbol);

        pos_new = r_pos_q;
        neg_new = r_neg_q;
        if (r_mode == dsc_pkg::MODE_CHECK) begin
            if (r_label) pos_new = (r_pos_q == '1) ? r_pos_q : r_pos_q + 1'b1;
            else         neg_new = (r_neg_q == '1) ? r_neg_q : r_neg_q + 1'b1;
        end
        n_cur_step = r_pair_ok ? r_trans_q : cur_now;
        seen_step  = (r_in_str ? r_seen : 1'b1) && r_pair_ok && (pos_new != '0);

        // Clearing pass overrides everything else
        trans_we = 1'b0;
        trans_wa = r_sweep_cnt;
        trans_wd = '0;
        cnt_we      = 1'b0;
        cnt_pos_sel = 1'b1;
        cnt_wa      = r_sweep_cnt;
        pos_wd      = '0;
        neg_wd      = '0;
        acc_we = 1'b0;
        acc_wa = SW'(r_sweep_cnt);
        acc_wd = 1'b0;
        if (i_cmd.sweep) begin
            trans_we = 1'b1;
            cnt_we   = 1'b1;
            acc_we   = (32'(r_sweep_cnt) < dsc_pkg::MAX_STATES);
        end else begin
            if (i_cmd.take && (i_opcode == dsc_pkg::OP_WR_TRANS)
                    && pair_ok(i_state_index, i_symbol)) begin
                trans_we = 1'b1;
                trans_wa = pair_at(i_state_index, i_symbol);
                trans_wd = i_next_state;
            end
            if (i_cmd.take && (i_opcode == dsc_pkg::OP_WR_ACC)
                    && (32'(i_state_index) < dsc_pkg::MAX_STATES)) begin
                acc_we = 1'b1;
                acc_wa = SW'(i_state_index);
                acc_wd = i_accepting;
            end
            if (i_cmd.step && r_pair_ok && (r_mode == dsc_pkg::MODE_CHECK)) begin
                cnt_we      = 1'b1;
                cnt_pos_sel = r_label;
                cnt_wa      = r_pair;
                pos_wd      = pos_new;
                neg_wd      = neg_new;
            end
        end

        // Flag lookup: the next state during a step, else the current one
        acc_re  = i_cmd.take || i_cmd.step;
        acc_rst = i_cmd.step ? n_cur_step : cur_now;

        fin_st  = r_in_str ? r_cur : r_start;
        fin_acc = r_acc_q && r_acc_ok;
        n_ok    = r_ok;
        n_ones  = r_ones;
        n_zeros = r_zeros;
        if (r_mode == dsc_pkg::MODE_CHECK) begin
            fin_verdict = (fin_acc == r_label);
            n_ok        = r_ok && fin_verdict;
        end else begin
            fin_verdict = (r_in_str ? r_seen : 1'b1) && fin_acc;
            if (fin_verdict) n_ones  = (r_ones == '1) ? r_ones : r_ones + 1'b1;
            else             n_zeros = (r_zeros == '1) ? r_zeros : r_zeros + 1'b1;
        end

        sum   = r_pair_ok ? SUM_W'(r_pos_q) + SUM_W'(r_neg_q) : '0;
        visit = (sum > SUM_W'(VISIT_MAX)) ? VISIT_MAX : sum[VW-1:0];
    end

    // Memory ports
    always_ff @(posedge i_clk) begin
        if (trans_we) mem_trans[trans_wa] <= trans_wd;
        if (i_cmd.take) r_trans_q <= mem_trans[rd_pair];
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we && (cnt_pos_sel || i_cmd.sweep)) mem_pos[cnt_wa] <= pos_wd;
        if (i_cmd.take) r_pos_q <= mem_pos[rd_pair];
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we && (!cnt_pos_sel || i_cmd.sweep)) mem_neg[cnt_wa] <= neg_wd;
        if (i_cmd.take) r_neg_q <= mem_neg[rd_pair];
    end

    always_ff @(posedge i_clk) begin
        if (acc_we) mem_acc[acc_wa] <= acc_wd;
        if (acc_re) begin
            r_acc_q  <= mem_acc[SW'(acc_rst)];
            r_acc_ok <= (32'(acc_rst) < dsc_pkg::MAX_STATES);
        end
    end

    // Held item
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_label   <= i_label;
            r_last    <= i_last_symbol;
            r_pair    <= rd_pair;
            r_pair_ok <= rd_pair_ok;
        end
    end

    // Control, configuration and string state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep_cnt <= '0;
            r_start     <= '0;
            r_mode      <= dsc_pkg::MODE_CHECK;
            r_cur       <= '0;
            r_in_str    <= 1'b0;
            r_seen      <= 1'b1;
            r_ok        <= 1'b1;
            r_ones      <= '0;
            r_zeros     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.sweep) r_sweep_cnt <= r_sweep_cnt + 1'b1;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    dsc_pkg::CFG_INIT_STATE: r_start <= i_cfg_data;
                    dsc_pkg::CFG_RUN_MODE:   r_mode  <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.step) begin
                r_cur    <= n_cur_step;
                r_in_str <= 1'b1;
                r_seen   <= seen_step;
            end
            if (i_cmd.finish) begin
                r_ok     <= n_ok;
                r_ones   <= n_ones;
                r_zeros  <= n_zeros;
                r_in_str <= 1'b0;
                r_seen   <= 1'b1;
            end
            if (i_cmd.finish || i_cmd.readout) r_out_valid <= 1'b1;
            else if (i_m_tready)               r_out_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_kind    <= dsc_pkg::KIND_VERDICT;
            r_out_verdict <= fin_verdict;
            r_out_end     <= fin_st;
            r_out_visit   <= '0;
            r_out_ok      <= n_ok;
            r_out_ones    <= n_ones;
            r_out_zeros   <= n_zeros;
        end else if (i_cmd.readout) begin
            r_out_kind    <= dsc_pkg::KIND_COUNT;
            r_out_verdict <= 1'b0;
            r_out_end     <= '0;
            r_out_visit   <= visit;
            r_out_ok      <= r_ok;
            r_out_ones    <= r_ones;
            r_out_zeros   <= r_zeros;
        end
    end

    always_comb begin
        o_sts.sweep_last = (r_sweep_cnt == PW'(dsc_pkg::PAIRS - 1));
        o_sts.out_free   = !r_out_valid || i_m_tready;
        o_sts.item_last  = r_last;
        o_m_tvalid = r_out_valid;
        o_m_tuser  = r_out_kind;
        o_m_tdata  = {5'b0, r_out_zeros, r_out_ones, r_out_ok, r_out_visit,
                      r_out_end, r_out_verdict};
    end

endmodule
